@@ rtl/afd_pkg.sv @@
// Shared constants and types for the acknowledgement frame deframer.
package afd_pkg;

   // Frame layout
   localparam int MIN_FRAME       = 8;
   localparam int SECOND_START    = 8;
   localparam int PAYLOAD_START   = 9;
   localparam int FRAME_OVERHEAD  = 11;
   localparam int LAST_ACK_BYTE   = 4;
   localparam int XOR_START       = 3;
   localparam int MAX_FRAME_LEN_DEFAULT = 256;

   // Register reset values
   localparam logic [7:0] HEADER_RESET = 8'd245;
   localparam logic [7:0] TAIL_RESET   = 8'd245;

   // Configuration register indexes
   localparam logic CSR_HEADER = 1'b0;
   localparam logic CSR_TAIL   = 1'b1;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [2:0] {
      STATUS_SHORT_OK = 3'd0,
      STATUS_LONG_OK  = 3'd1,
      STATUS_LONG_BAD = 3'd2,
      STATUS_REJECTED = 3'd3,
      STATUS_OVERFLOW = 3'd4
   } status_type;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] payload_byte;
      logic [7:0] ack_command;
      logic [7:0] ack_param_one;
      logic [7:0] ack_param_two;
      logic [7:0] ack_outcome;
      status_type frame_status;
      logic [7:0] payload_count;
   } rsp_item_type;

endpackage

@@ rtl/ack_frame_deframer_xor_check_top.sv @@
// Top level of the acknowledgement frame deframer with XOR checksum.
//
// The req_ stream carries one received byte per transfer in req_tdata, with
// req_tlast on the last byte of a buffer. The rsp_ stream returns payload
// bytes of a long frame (rsp_tuser low) as the byte after each one arrives,
// and one status item (rsp_tuser high) per buffer, carrying bytes 1 to 4,
// the verdict and the number of payload bytes streamed.
// The csr_ port writes the header byte (index 0) and tail byte (index 1);
// write them only while no buffer is in flight.
// Each byte is captured in an input register, parsed by single-cycle logic
// and its result, if any, lands in an output register that drives rsp_.
// One byte is accepted per cycle; the rate is set only by the output
// register, which frees as it is taken.
// When the receiver stalls, bytes that produce no result keep flowing, and
// a byte with a result waits in the input register until the output frees.
// Synchronous reset empties both registers, clears all buffer state and
// sets the header and tail bytes to 245.
module ack_frame_deframer_xor_check_top #(
   parameter int MAX_FRAME_LEN = afd_pkg::MAX_FRAME_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] payload_byte, [15:8] ack_command, [23:16] ack_param_one,
   // [31:24] ack_param_two, [39:32] ack_outcome, [42:40] frame_status,
   // [50:43] payload_count, [55:51] zero
   output logic [55:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] out_kind
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0] header_ff, tail_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   afd_pkg::rsp_item_type out_ff;
   afd_pkg::rsp_item_type res;
   logic       res_valid;
   logic       out_free;
   logic       advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= afd_pkg::HEADER_RESET;
         tail_ff   <= afd_pkg::TAIL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            afd_pkg::CSR_HEADER: header_ff <= csr_wdata;
            afd_pkg::CSR_TAIL:   tail_ff   <= csr_wdata;
            default:             header_ff <= header_ff;
         endcase
      end
   end

   afd_parse #(
      .MAX_FRAME_LEN(MAX_FRAME_LEN)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .rx_byte      (in_byte_ff),
      .frame_end    (in_last_ff),
      .header_value (header_ff),
      .tail_value   (tail_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!res_valid || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && res_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.out_kind;
   assign rsp_tdata  = {5'b00000, out_ff.payload_count, out_ff.frame_status,
                        out_ff.ack_outcome, out_ff.ack_param_two, out_ff.ack_param_one,
                        out_ff.ack_command, out_ff.payload_byte};

endmodule

@@ rtl/afd_parse.sv @@
// Per-buffer parse state: checksums, ack fields, delay line and result building.
module afd_parse #(
   parameter int MAX_FRAME_LEN = afd_pkg::MAX_FRAME_LEN_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           rx_byte,
   input  logic                 frame_end,
   input  logic [7:0]           header_value,
   input  logic [7:0]           tail_value,
   output logic                 res_valid,
   output afd_pkg::rsp_item_type res
);

   localparam int IDX_W = $clog2(MAX_FRAME_LEN + 1);
   localparam int CNT_W = (IDX_W > 8) ? IDX_W : 8;
   localparam int OVF_COUNT_INT = (MAX_FRAME_LEN - 10 > 255) ? 255 : MAX_FRAME_LEN - 10;
   localparam logic [7:0] OVF_COUNT = 8'(OVF_COUNT_INT);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_FRAME_LEN);
   localparam logic [IDX_W-1:0] IDX_XOR = IDX_W'(afd_pkg::XOR_START);
   localparam logic [IDX_W-1:0] IDX_SXOR = IDX_W'(afd_pkg::PAYLOAD_START + 2);
   localparam logic [IDX_W-1:0] IDX_SHORT = IDX_W'(afd_pkg::MIN_FRAME - 1);
   localparam logic [IDX_W-1:0] IDX_SECOND = IDX_W'(afd_pkg::SECOND_START);
   localparam logic [IDX_W-1:0] IDX_ACK_END = IDX_W'(afd_pkg::LAST_ACK_BYTE);
   localparam logic [IDX_W-1:0] IDX_PAYLOAD = IDX_W'(afd_pkg::PAYLOAD_START + 1);
   localparam logic [IDX_W-1:0] IDX_COUNT = IDX_W'(afd_pkg::FRAME_OVERHEAD - 1);
   localparam logic [IDX_W-1:0] IDX_SECOND_MIN =
      IDX_W'(afd_pkg::SECOND_START + afd_pkg::MIN_FRAME - 1);

   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [7:0]       first_byte_ff, first_byte_in;
   logic [7:0]       ack_ff [4];
   logic [7:0]       ack_in [4];
   logic [7:0]       whole_xor_ff, whole_xor_in;
   logic             short_ok_ff, short_ok_in;
   logic [7:0]       second_header_ff, second_header_in;
   logic [7:0]       second_xor_ff, second_xor_in;
   logic [7:0]       delay0_ff, delay0_in;
   logic [7:0]       delay1_ff, delay1_in;

   always_comb begin
      logic [IDX_W-1:0] i;
      logic [IDX_W-1:0] cnt_raw;
      logic [CNT_W-1:0] cnt_ext;
      logic [7:0]       cnt_sat;
      logic             whole_ok;
      logic             second_ok;
      logic             clear;

      i = byte_index_ff;
      byte_index_in    = byte_index_ff;
      first_byte_in    = first_byte_ff;
      ack_in           = ack_ff;
      whole_xor_in     = whole_xor_ff;
      short_ok_in      = short_ok_ff;
      second_header_in = second_header_ff;
      second_xor_in    = second_xor_ff;
      delay0_in        = delay0_ff;
      delay1_in        = delay1_ff;
      clear            = 1'b0;
      res_valid        = 1'b0;
      res              = '0;
      whole_ok         = 1'b0;
      second_ok        = 1'b0;

      cnt_raw = (i >= IDX_COUNT) ? i - IDX_COUNT : '0;
      cnt_ext = CNT_W'(cnt_raw);
      cnt_sat = (cnt_ext > CNT_W'(255)) ? 8'hFF : cnt_ext[7:0];

      if (i < IDX_MAX) begin
         // The byte two places back leaves the delay line into the checksums.
         if (i >= IDX_XOR) begin
            whole_xor_in = whole_xor_ff ^ delay1_ff;
         end
         if (i >= IDX_SXOR) begin
            second_xor_in = second_xor_ff ^ delay1_ff;
         end

         if (i == '0) begin
            first_byte_in = rx_byte;
         end else if (i <= IDX_ACK_END) begin
            ack_in[2'(i - IDX_W'(1))] = rx_byte;
         end else if (i == IDX_SECOND) begin
            second_header_in = rx_byte;
         end

         if (i == IDX_SHORT) begin
            short_ok_in = (first_byte_ff == header_value) && (rx_byte == tail_value) &&
                          (whole_xor_in == delay0_ff);
         end

         if (!frame_end) begin
            delay1_in     = delay0_ff;
            delay0_in     = rx_byte;
            byte_index_in = i + IDX_W'(1);
            if (i >= IDX_PAYLOAD) begin
               res_valid        = 1'b1;
               res.out_kind     = afd_pkg::KIND_PAYLOAD;
               res.payload_byte = delay0_ff;
            end
         end else begin
            whole_ok = (i >= IDX_SHORT) && (first_byte_in == header_value) &&
                       (rx_byte == tail_value) && (whole_xor_in == delay0_ff);
            second_ok = (i >= IDX_SECOND_MIN) && (second_header_in == header_value) &&
                        (rx_byte == tail_value) && (second_xor_in == delay0_ff);
            res_valid         = 1'b1;
            res.out_kind      = afd_pkg::KIND_STATUS;
            res.payload_count = cnt_sat;
            if (!whole_ok) begin
               res.frame_status = afd_pkg::STATUS_REJECTED;
            end else if (i == IDX_SHORT) begin
               res.frame_status = afd_pkg::STATUS_SHORT_OK;
            end else if (!short_ok_in) begin
               res.frame_status = afd_pkg::STATUS_REJECTED;
            end else if (second_ok) begin
               res.frame_status = afd_pkg::STATUS_LONG_OK;
            end else begin
               res.frame_status = afd_pkg::STATUS_LONG_BAD;
            end
            clear = 1'b1;
         end
      end else if (frame_end) begin
         // Saturated index: bytes past the limit were dropped.
         res_valid         = 1'b1;
         res.out_kind      = afd_pkg::KIND_STATUS;
         res.frame_status  = afd_pkg::STATUS_OVERFLOW;
         res.payload_count = OVF_COUNT;
         clear             = 1'b1;
      end

      if (res.out_kind == afd_pkg::KIND_STATUS) begin
         res.ack_command   = ack_in[0];
         res.ack_param_one = ack_in[1];
         res.ack_param_two = ack_in[2];
         res.ack_outcome   = ack_in[3];
      end

      if (clear) begin
         byte_index_in    = '0;
         first_byte_in    = '0;
         ack_in           = '{default: 8'h00};
         whole_xor_in     = '0;
         short_ok_in      = 1'b0;
         second_header_in = '0;
         second_xor_in    = '0;
         delay0_in        = '0;
         delay1_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff    <= '0;
         first_byte_ff    <= '0;
         ack_ff           <= '{default: 8'h00};
         whole_xor_ff     <= '0;
         short_ok_ff      <= 1'b0;
         second_header_ff <= '0;
         second_xor_ff    <= '0;
         delay0_ff        <= '0;
         delay1_ff        <= '0;
      end else if (step_en) begin
         byte_index_ff    <= byte_index_in;
         first_byte_ff    <= first_byte_in;
         ack_ff           <= ack_in;
         whole_xor_ff     <= whole_xor_in;
         short_ok_ff      <= short_ok_in;
         second_header_ff <= second_header_in;
         second_xor_ff    <= second_xor_in;
         delay0_ff        <= delay0_in;
         delay1_ff        <= delay1_in;
      end
   end

endmodule
